[hw/rtl/assert_macros.svh]
// Assertion macros for the RTL files that check their own behavior.
// Depends on nothing; expects aclk and aresetn in the including scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define ECF_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("ecf assertion failed");

// Next-cycle implication, disabled in reset.
`define ECF_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("ecf assertion failed");

`endif

[hw/rtl/ecf_pkg.sv]
// Shared types and constants of the elevation cell fusion unit.
// Used by the controller, the datapath and the top level.
`timescale 1ns / 1ps
package ecf_pkg;

    localparam int GRID_COLS  = 128;
    localparam int GRID_ROWS  = 128;
    localparam int CELL_COUNT = GRID_COLS * GRID_ROWS;
    localparam int COL_W      = $clog2(GRID_COLS);
    localparam int ROW_W      = $clog2(GRID_ROWS);
    localparam int ADDR_W     = $clog2(CELL_COUNT);

    localparam int IN_IDX_W   = 7;
    localparam int S_TDATA_W  = 80;
    localparam int M_TDATA_W  = 64;

    // operation codes
    localparam logic OP_FUSE  = 1'b0;
    localparam logic OP_SWEEP = 1'b1;

    // result status codes
    localparam logic [1:0] ST_INIT   = 2'd0;
    localparam logic [1:0] ST_FUSED  = 2'd1;
    localparam logic [1:0] ST_REJECT = 2'd2;
    localparam logic [1:0] ST_SWEEP  = 2'd3;

    // register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_PV   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GATE_THR = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_VAR_MIN  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_VAR_MAX  = 2'd3;

    // result selection
    localparam logic [2:0] RES_NONE     = 3'd0;
    localparam logic [2:0] RES_INIT     = 3'd1;
    localparam logic [2:0] RES_REJ_ZERO = 3'd2;
    localparam logic [2:0] RES_REJ      = 3'd3;
    localparam logic [2:0] RES_KEEP     = 3'd4;
    localparam logic [2:0] RES_FUSED    = 3'd5;
    localparam logic [2:0] RES_SWEEP    = 3'd6;

    typedef struct packed {
        logic       load;
        logic       fuse_rd;
        logic       calc_d;
        logic       init_wr;
        logic       mul_gate;
        logic       mul_upd;
        logic       div1_go;
        logic       div1_take;
        logic       div2_go;
        logic       div2_take;
        logic       upd_wr;
        logic       sw_rd;
        logic       sw_wr;
        logic       scan_next;
        logic       clr_wr;
        logic       out_load;
        logic [2:0] res_sel;
    } ecf_cmd_t;

    typedef struct packed {
        logic is_sweep;
        logic out_of_grid;
        logic cell_valid;
        logic gate_fail;
        logic sum_zero;
        logic div_done;
        logic scan_last;
        logic row_last;
        logic out_free;
    } ecf_sts_t;

endpackage

[hw/rtl/ecf_div.sv]
// Radix-2 restoring divider, one quotient bit per cycle, 32 quotient bits.
// Needs a dividend whose upper half is below the divisor. Uses ecf_pkg.
`timescale 1ns / 1ps
module ecf_div
    import ecf_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [63:0] dividend,
    input  logic [32:0] divisor,
    output logic        done,
    output logic [31:0] quotient
);

    localparam int STEPS = 32;
    localparam int CNT_W = $clog2(STEPS + 1);

    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             done_reg, done_next;
    logic [32:0]      rem_reg, rem_next;
    logic [31:0]      low_reg, low_next;
    logic [33:0]      trial;
    logic             ge;

    assign trial = {rem_reg, low_reg[31]};
    assign ge    = trial >= {1'b0, divisor};

    always_comb begin
        cnt_next  = cnt_reg;
        done_next = done_reg;
        rem_next  = rem_reg;
        low_next  = low_reg;
        if (start) begin
            cnt_next  = CNT_W'(STEPS);
            done_next = 1'b0;
            rem_next  = {1'b0, dividend[63:32]};
            low_next  = dividend[31:0];
        end else if (cnt_reg != '0) begin
            rem_next = ge ? 33'(trial - {1'b0, divisor}) : trial[32:0];
            low_next = {low_reg[30:0], ge};
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1)) begin
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
        rem_reg <= rem_next;
        low_reg <= low_next;
    end

    assign done     = done_reg;
    assign quotient = low_reg;

endmodule

[hw/rtl/ecf_datapath.sv]
// Datapath: cell stores, gate and Kalman arithmetic, result and output register.
// Uses ecf_pkg and instantiates ecf_div.
`timescale 1ns / 1ps
module ecf_datapath
    import ecf_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  ecf_cmd_t             cmd,
    output ecf_sts_t             sts,
    input  logic                 s_tuser,
    input  logic [S_TDATA_W-1:0] s_tdata,
    input  logic [31:0]          min_pv,
    input  logic [15:0]          gate_thr,
    input  logic [31:0]          var_min,
    input  logic [31:0]          var_max,
    input  logic                 m_tready,
    output logic                 m_tvalid,
    output logic [1:0]           m_tuser,
    output logic [M_TDATA_W-1:0] m_tdata
);

    // cell stores
    logic signed [31:0]  height_mem [CELL_COUNT];
    logic [31:0]         var_mem    [CELL_COUNT];
    logic [GRID_COLS-1:0] valid_mem [GRID_ROWS];

    logic                 op_reg;
    logic                 oog_reg;
    logic [COL_W-1:0]     col_reg;
    logic [ROW_W-1:0]     row_reg;
    logic signed [31:0]   z_reg;
    logic [31:0]          pv_reg;

    logic signed [31:0]   h_rd;
    logic [31:0]          v_rd;
    logic [GRID_COLS-1:0] vrow_rd;

    logic                 neg_reg;
    logic [32:0]          d_reg;
    logic [55:0]          dd_reg;
    logic [47:0]          tv_reg;
    logic [32:0]          s_reg;
    logic                 big_reg;
    logic [63:0]          p1_reg;
    logic [63:0]          p2_reg;
    logic [31:0]          q_reg;
    logic [31:0]          nv_reg;

    logic [1:0]           res_st_reg;
    logic [31:0]          res_h_reg;
    logic [31:0]          res_v_reg;
    logic                 m_valid_reg;
    logic [1:0]           m_st_reg;
    logic [31:0]          m_h_reg;
    logic [31:0]          m_v_reg;

    logic [ADDR_W-1:0]    addr;
    logic [IN_IDX_W-1:0]  in_col;
    logic [IN_IDX_W-1:0]  in_row;
    logic [31:0]          in_pv;
    logic signed [32:0]   diff;
    logic signed [31:0]   e_new;
    logic [31:0]          clamp_lo;
    logic [31:0]          clamp_v;
    logic                 cell_valid;
    logic                 h_we;
    logic                 v_we;
    logic                 vld_we;
    logic [31:0]          h_wd;
    logic [31:0]          v_wd;
    logic [GRID_COLS-1:0] vld_wd;
    logic                 div_go;
    logic [63:0]          div_n;
    logic                 div_done;
    logic [31:0]          div_q;

    assign in_col = s_tdata[6:0];
    assign in_row = s_tdata[13:7];
    assign in_pv  = s_tdata[77:46];
    assign addr   = ADDR_W'(32'(row_reg) * GRID_COLS + 32'(col_reg));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
        end else if (cmd.load) begin
            if (s_tuser == OP_SWEEP) begin
                col_reg <= '0;
                row_reg <= '0;
            end else begin
                col_reg <= COL_W'(in_col);
                row_reg <= ROW_W'(in_row);
            end
        end else if (cmd.clr_wr) begin
            row_reg <= (row_reg == ROW_W'(GRID_ROWS - 1)) ? '0 : row_reg + ROW_W'(1);
        end else if (cmd.scan_next) begin
            if (col_reg == COL_W'(GRID_COLS - 1)) begin
                col_reg <= '0;
                row_reg <= row_reg + ROW_W'(1);
            end else begin
                col_reg <= col_reg + COL_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg  <= s_tuser;
            oog_reg <= (32'(in_col) >= 32'(GRID_COLS)) || (32'(in_row) >= 32'(GRID_ROWS));
            z_reg   <= s_tdata[45:14];
            pv_reg  <= (in_pv < min_pv) ? min_pv : in_pv;
        end
    end

    // stores: registered reads
    assign cell_valid = vrow_rd[col_reg];
    assign diff       = 33'(z_reg) - 33'(h_rd);
    assign e_new      = neg_reg ? h_rd - $signed(q_reg) : h_rd + $signed(q_reg);
    assign clamp_lo   = (v_rd < var_min) ? var_min : v_rd;
    assign clamp_v    = (clamp_lo > var_max) ? var_max : clamp_lo;

    assign h_we   = cmd.init_wr | cmd.upd_wr;
    assign h_wd   = cmd.init_wr ? z_reg : e_new;
    assign v_we   = cmd.init_wr | cmd.upd_wr | (cmd.sw_wr & cell_valid);
    assign v_wd   = cmd.init_wr ? pv_reg : (cmd.upd_wr ? nv_reg : clamp_v);
    assign vld_we = cmd.init_wr | cmd.clr_wr;
    assign vld_wd = cmd.clr_wr ? '0 : (vrow_rd | (GRID_COLS'(1) << col_reg));

    always_ff @(posedge aclk) begin
        if (h_we) begin
            height_mem[addr] <= h_wd;
        end
        if (cmd.fuse_rd) begin
            h_rd <= height_mem[addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (v_we) begin
            var_mem[addr] <= v_wd;
        end
        if (cmd.fuse_rd | cmd.sw_rd) begin
            v_rd <= var_mem[addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (vld_we) begin
            valid_mem[row_reg] <= vld_wd;
        end
        if (cmd.fuse_rd | cmd.sw_rd) begin
            vrow_rd <= valid_mem[row_reg];
        end
    end

    // gate and update arithmetic
    always_ff @(posedge aclk) begin
        if (cmd.calc_d) begin
            neg_reg <= diff < 0;
            d_reg   <= (diff < 0) ? 33'(-diff) : 33'(diff);
        end
        if (cmd.mul_gate) begin
            dd_reg  <= 56'(d_reg[27:0]) * 56'(d_reg[27:0]);
            tv_reg  <= 48'(gate_thr) * 48'(v_rd);
            s_reg   <= 33'(v_rd) + 33'(pv_reg);
            big_reg <= |d_reg[32:28];
        end
        if (cmd.mul_upd) begin
            p1_reg <= 64'(v_rd) * 64'(d_reg[27:0]);
            p2_reg <= 64'(pv_reg) * 64'(v_rd);
        end
        if (cmd.div1_take) begin
            q_reg <= div_q;
        end
        if (cmd.div2_take) begin
            nv_reg <= div_q;
        end
    end

    // add half the divisor for round to nearest
    assign div_go = cmd.div1_go | cmd.div2_go;
    assign div_n  = (cmd.div1_go ? p1_reg : p2_reg) + 64'(s_reg[32:1]);

    ecf_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_go),
        .dividend (div_n),
        .divisor  (s_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    always_ff @(posedge aclk) begin
        unique case (cmd.res_sel)
            RES_INIT: begin
                res_st_reg <= ST_INIT;
                res_h_reg  <= z_reg;
                res_v_reg  <= pv_reg;
            end
            RES_REJ_ZERO: begin
                res_st_reg <= ST_REJECT;
                res_h_reg  <= '0;
                res_v_reg  <= '0;
            end
            RES_REJ: begin
                res_st_reg <= ST_REJECT;
                res_h_reg  <= h_rd;
                res_v_reg  <= v_rd;
            end
            RES_KEEP: begin
                res_st_reg <= ST_FUSED;
                res_h_reg  <= h_rd;
                res_v_reg  <= v_rd;
            end
            RES_FUSED: begin
                res_st_reg <= ST_FUSED;
                res_h_reg  <= e_new;
                res_v_reg  <= nv_reg;
            end
            RES_SWEEP: begin
                res_st_reg <= ST_SWEEP;
                res_h_reg  <= '0;
                res_v_reg  <= '0;
            end
            default: begin
            end
        endcase
    end

    // output word register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
        if (cmd.out_load) begin
            m_st_reg <= res_st_reg;
            m_h_reg  <= res_h_reg;
            m_v_reg  <= res_v_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_st_reg;
    assign m_tdata  = {m_v_reg, m_h_reg};

    assign sts.is_sweep    = op_reg;
    assign sts.out_of_grid = oog_reg;
    assign sts.cell_valid  = cell_valid;
    assign sts.gate_fail   = big_reg | ({dd_reg, 8'b0} > {16'b0, tv_reg});
    assign sts.sum_zero    = s_reg == '0;
    assign sts.div_done    = div_done;
    assign sts.scan_last   = (col_reg == COL_W'(GRID_COLS - 1))
                          && (row_reg == ROW_W'(GRID_ROWS - 1));
    assign sts.row_last    = row_reg == ROW_W'(GRID_ROWS - 1);
    assign sts.out_free    = !m_valid_reg | m_tready;

endmodule

[hw/rtl/ecf_ctrl.sv]
// Controller state machine: sequences the valid clear, fuse steps and the sweep.
// Uses ecf_pkg; drives ecf_datapath through ecf_cmd_t.
`timescale 1ns / 1ps
module ecf_ctrl
    import ecf_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     in_valid,
    output logic     in_ready,
    input  ecf_sts_t sts,
    output ecf_cmd_t cmd
);

    localparam logic [3:0] S_CLR  = 4'd0;
    localparam logic [3:0] S_IDLE = 4'd1;
    localparam logic [3:0] S_FRD  = 4'd2;
    localparam logic [3:0] S_FCHK = 4'd3;
    localparam logic [3:0] S_MUL  = 4'd4;
    localparam logic [3:0] S_GATE = 4'd5;
    localparam logic [3:0] S_D1S  = 4'd6;
    localparam logic [3:0] S_D1W  = 4'd7;
    localparam logic [3:0] S_D2S  = 4'd8;
    localparam logic [3:0] S_D2W  = 4'd9;
    localparam logic [3:0] S_UPD  = 4'd10;
    localparam logic [3:0] S_SRD  = 4'd11;
    localparam logic [3:0] S_SWR  = 4'd12;
    localparam logic [3:0] S_DONE = 4'd13;

    logic [3:0] state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        cmd.res_sel = RES_NONE;
        in_ready   = 1'b0;
        unique case (state_reg)
            S_CLR: begin
                cmd.clr_wr = 1'b1;
                if (sts.row_last) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    cmd.load   = 1'b1;
                    state_next = S_FRD;
                end
            end
            S_FRD: begin
                priority if (sts.is_sweep) begin
                    state_next = S_SRD;
                end else if (sts.out_of_grid) begin
                    cmd.res_sel = RES_REJ_ZERO;
                    state_next  = S_DONE;
                end else begin
                    cmd.fuse_rd = 1'b1;
                    state_next  = S_FCHK;
                end
            end
            S_FCHK: begin
                cmd.calc_d = 1'b1;
                if (sts.cell_valid) begin
                    state_next = S_MUL;
                end else begin
                    cmd.init_wr = 1'b1;
                    cmd.res_sel = RES_INIT;
                    state_next  = S_DONE;
                end
            end
            S_MUL: begin
                cmd.mul_gate = 1'b1;
                state_next   = S_GATE;
            end
            S_GATE: begin
                priority if (sts.gate_fail) begin
                    cmd.res_sel = RES_REJ;
                    state_next  = S_DONE;
                end else if (sts.sum_zero) begin
                    cmd.res_sel = RES_KEEP;
                    state_next  = S_DONE;
                end else begin
                    cmd.mul_upd = 1'b1;
                    state_next  = S_D1S;
                end
            end
            S_D1S: begin
                cmd.div1_go = 1'b1;
                state_next  = S_D1W;
            end
            S_D1W: begin
                if (sts.div_done) begin
                    cmd.div1_take = 1'b1;
                    state_next    = S_D2S;
                end
            end
            S_D2S: begin
                cmd.div2_go = 1'b1;
                state_next  = S_D2W;
            end
            S_D2W: begin
                if (sts.div_done) begin
                    cmd.div2_take = 1'b1;
                    state_next    = S_UPD;
                end
            end
            S_UPD: begin
                cmd.upd_wr  = 1'b1;
                cmd.res_sel = RES_FUSED;
                state_next  = S_DONE;
            end
            S_SRD: begin
                cmd.sw_rd  = 1'b1;
                state_next = S_SWR;
            end
            S_SWR: begin
                cmd.sw_wr = 1'b1;
                if (sts.scan_last) begin
                    cmd.res_sel = RES_SWEEP;
                    state_next  = S_DONE;
                end else begin
                    cmd.scan_next = 1'b1;
                    state_next    = S_SRD;
                end
            end
            S_DONE: begin
                // hold until the output register can take the word
                if (sts.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLR;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

[hw/rtl/elevation_cell_kalman_fusion_unit.sv]
// Top level of the elevation cell fusion unit: register port, controller, datapath.
// Uses ecf_pkg, ecf_ctrl, ecf_datapath and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Fuses height points into a 128 x 128 grid of cells with a per-cell Kalman
// filter and answers every input word with one result word. One word is in
// work at a time. After reset the unit clears its cell valid flags one grid row
// per cycle and takes no input word during that pass. A point into an empty
// cell opens the cell, a point outside the grid is rejected without a store
// read, and a point that the gate rejects or that meets a zero variance sum
// leaves the cell as it is; a fused point makes two passes of the shared
// bit-serial divider, each a start and a wait for its 32 quotient bits. The
// end-of-cloud sweep visits every cell, a read and then a write per cell,
// through the variance store port. A finished result waits in the output
// register while the next input word is taken.
module elevation_cell_kalman_fusion_unit
    import ecf_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // cell_col[6:0], cell_row[13:7], point_height[45:14], point_variance[77:46]
    input  logic [S_TDATA_W-1:0] s_tdata,
    // op[0]
    input  logic                 s_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // cell_height[31:0], cell_variance[63:32]
    output logic [M_TDATA_W-1:0] m_tdata,
    // status[1:0]
    output logic [1:0]           m_tuser,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [3:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);

    logic [31:0] min_pv_reg;
    logic [15:0] gate_thr_reg;
    logic [31:0] var_min_reg;
    logic [31:0] var_max_reg;
    logic [CFG_IDX_W-1:0] reg_idx;
    logic        cfg_we;
    ecf_cmd_t    cmd;
    ecf_sts_t    sts;

    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];
    assign cfg_we  = psel & penable & pwrite & pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_pv_reg   <= 32'd429497;
            gate_thr_reg <= 16'd1600;
            var_min_reg  <= 32'd429497;
            var_max_reg  <= 32'd214748365;
        end else if (cfg_we) begin
            unique case (reg_idx)
                REG_MIN_PV:   min_pv_reg   <= pwdata;
                REG_GATE_THR: gate_thr_reg <= pwdata[15:0];
                REG_VAR_MIN:  var_min_reg  <= pwdata;
                REG_VAR_MAX:  var_max_reg  <= pwdata;
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_MIN_PV:   prdata = min_pv_reg;
            REG_GATE_THR: prdata = {16'b0, gate_thr_reg};
            REG_VAR_MIN:  prdata = var_min_reg;
            REG_VAR_MAX:  prdata = var_max_reg;
            default:      prdata = '0;
        endcase
    end

    ecf_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    ecf_datapath u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .sts      (sts),
        .s_tuser  (s_tuser),
        .s_tdata  (s_tdata),
        .min_pv   (min_pv_reg),
        .gate_thr (gate_thr_reg),
        .var_min  (var_min_reg),
        .var_max  (var_max_reg),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .m_tuser  (m_tuser),
        .m_tdata  (m_tdata)
    );

    `ECF_ASSERT_NXT(a_one_in_work, s_tvalid && s_tready, !s_tready)
    `ECF_ASSERT_IMP(a_sweep_zero, $rose(m_tvalid) && m_tuser == ST_SWEEP, m_tdata == '0)
    `ECF_ASSERT_IMP(a_init_floor, $rose(m_tvalid) && m_tuser == ST_INIT, m_tdata[63:32] >= min_pv_reg)

endmodule

[sim/testbench.sv]
// Self-checking testbench of the elevation cell fusion unit: streams points and
// sweeps in, predicts every result word and compares it field by field.
// Depends on ecf_pkg and elevation_cell_kalman_fusion_unit.
`timescale 1ns / 1ps

typedef struct {
    logic [1:0]  status;
    logic [31:0] height;
    logic [31:0] variance;
} cell_result_t;

class cell_fusion_board;
    bit [31:0]    min_pv;
    bit [15:0]    gate_thr;
    bit [31:0]    var_lo;
    bit [31:0]    var_hi;
    bit [31:0]    height_mem [ecf_pkg::CELL_COUNT];
    bit [31:0]    var_mem [ecf_pkg::CELL_COUNT];
    bit           valid_mem [ecf_pkg::CELL_COUNT];
    cell_result_t pending_q [$];
    int           mismatches;

    function new();
        min_pv     = 429497;
        gate_thr   = 1600;
        var_lo     = 429497;
        var_hi     = 214748365;
        mismatches = 0;
        foreach (valid_mem[i]) valid_mem[i] = 1'b0;
    endfunction

    function void set_reg(logic [1:0] idx, bit [31:0] val);
        case (idx)
            ecf_pkg::REG_MIN_PV:   min_pv   = val;
            ecf_pkg::REG_GATE_THR: gate_thr = val[15:0];
            ecf_pkg::REG_VAR_MIN:  var_lo   = val;
            default:               var_hi   = val;
        endcase
    endfunction

    // predict the result of one accepted word and update the cell copy
    function void note(bit op, bit [6:0] col, bit [6:0] row, bit [31:0] z, bit [31:0] pv_in);
        cell_result_t r;
        int           idx;
        longint       zl, el;
        bit           neg;
        bit [63:0]    d, pv, cv, s, q, nv, thr;
        idx = row * ecf_pkg::GRID_COLS + col;
        if (op == ecf_pkg::OP_SWEEP) begin
            foreach (valid_mem[i]) begin
                if (valid_mem[i]) begin
                    if (var_mem[i] < var_lo) var_mem[i] = var_lo;
                    if (var_mem[i] > var_hi) var_mem[i] = var_hi;
                end
            end
            r = '{ecf_pkg::ST_SWEEP, 32'd0, 32'd0};
        end else begin
            pv = (pv_in < min_pv) ? min_pv : pv_in;
            if (!valid_mem[idx]) begin
                height_mem[idx] = z;
                var_mem[idx]    = pv[31:0];
                valid_mem[idx]  = 1'b1;
                r = '{ecf_pkg::ST_INIT, z, pv[31:0]};
            end else begin
                zl  = longint'($signed(z));
                el  = longint'($signed(height_mem[idx]));
                cv  = var_mem[idx];
                thr = gate_thr;
                neg = zl < el;
                d   = neg ? el - zl : zl - el;
                if (d >= 64'h1000_0000 || d * d * 256 > thr * cv) begin
                    r = '{ecf_pkg::ST_REJECT, height_mem[idx], var_mem[idx]};
                end else begin
                    s = cv + pv;
                    if (s != 0) begin
                        q  = (cv * d + s / 2) / s;
                        nv = (pv * cv + s / 2) / s;
                        el = neg ? el - longint'(q) : el + longint'(q);
                        height_mem[idx] = el[31:0];
                        var_mem[idx]    = nv[31:0];
                    end
                    r = '{ecf_pkg::ST_FUSED, height_mem[idx], var_mem[idx]};
                end
            end
        end
        pending_q.push_back(r);
    endfunction

    function void check(logic [1:0] status, logic [31:0] height, logic [31:0] variance);
        cell_result_t r;
        if (pending_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected word: status %0d height %h variance %h",
                         status, height, variance);
            return;
        end
        r = pending_q.pop_front();
        if (status !== r.status || height !== r.height || variance !== r.variance) begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch: expected %0d/%h/%h got %0d/%h/%h", r.status, r.height,
                         r.variance, status, height, variance);
        end
    endfunction

    function int outstanding();
        return pending_q.size();
    endfunction
endclass

module testbench;
    import ecf_pkg::*;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic                 s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [1:0]           m_tuser;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [3:0]           paddr;
    logic [31:0]          pwdata;
    logic [31:0]          prdata;
    logic                 pready;

    cell_fusion_board board;
    bit               no_idle;
    bit               long_hold;
    bit [13:0]        hot_cells [16];

    elevation_cell_kalman_fusion_unit dut (.*);

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    initial begin
        #(8 * 3_000_000);
        $display("simulation failed");
        $finish;
    end

    // result side: random stalls, one long hold on request
    initial begin
        int r;
        m_tready = 1'b0;
        @(posedge aclk iff aresetn);
        forever begin
            @(posedge aclk);
            r = $urandom_range(0, 99);
            if (long_hold) begin
                long_hold = 1'b0;
                m_tready <= 1'b0;
                repeat (500) @(posedge aclk);
            end else if (no_idle || r < 60) begin
                m_tready <= 1'b1;
            end else if (r < 95) begin
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b0;
                repeat ($urandom_range(10, 60)) @(posedge aclk);
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            board.check(m_tuser, m_tdata[31:0], m_tdata[63:32]);
    end

    task automatic write_reg(logic [1:0] idx, logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk iff pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        board.set_reg(idx, val);
    endtask

    task automatic configure(logic [31:0] pv_floor, logic [31:0] thr, logic [31:0] lo,
                             logic [31:0] hi);
        write_reg(REG_MIN_PV, pv_floor);
        write_reg(REG_GATE_THR, thr);
        write_reg(REG_VAR_MIN, lo);
        write_reg(REG_VAR_MAX, hi);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (board.outstanding() > 0) @(posedge aclk);
        repeat (100) @(posedge aclk);
    endtask

    task automatic send(bit op, bit [6:0] col, bit [6:0] row, bit [31:0] z, bit [31:0] pv);
        int r;
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {2'b00, pv, z, row, col};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        board.note(op, col, row, z, pv);
        r = $urandom_range(0, 99);
        if (!no_idle && r >= 70) begin
            s_tvalid <= 1'b0;
            repeat ((r < 95) ? $urandom_range(1, 3) : $urandom_range(10, 40)) @(posedge aclk);
        end
    endtask

    // point near the current cell height most of the time so the gate passes
    task automatic random_point();
        bit [13:0] pick;
        bit [31:0] z, pv;
        longint    zl;
        int        k, idx;
        pick = ($urandom_range(0, 4) != 0) ? hot_cells[$urandom_range(0, 15)] : 14'($urandom);
        idx  = pick[13:7] * GRID_COLS + pick[6:0];
        if (board.valid_mem[idx] && $urandom_range(0, 3) != 0) begin
            k  = $urandom_range(0, 22);
            zl = longint'($signed(board.height_mem[idx]));
            zl = ($urandom_range(0, 1) != 0) ? zl + $urandom_range(0, 1 << k)
                                               : zl - $urandom_range(0, 1 << k);
            if (zl > 64'sd2147483647) zl = 64'sd2147483647;
            if (zl < -64'sd2147483648) zl = -64'sd2147483648;
            z = zl[31:0];
        end else begin
            z = $urandom;
        end
        pv = ($urandom_range(0, 1) != 0) ? $urandom : $urandom_range(0, 1 << $urandom_range(0, 30));
        send(OP_FUSE, pick[6:0], pick[13:7], z, pv);
    endtask

    initial begin
        bit [31:0] cfg [5][4];
        board     = new();
        no_idle   = 1'b0;
        long_hold = 1'b0;
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = 1'b0;
        psel      = 1'b0;
        penable   = 1'b0;
        pwrite    = 1'b0;
        paddr     = '0;
        pwdata    = '0;
        foreach (hot_cells[i]) hot_cells[i] = 14'($urandom);
        cfg[0] = '{32'd429497, 32'd1600, 32'd429497, 32'd214748365};
        cfg[1] = '{32'hFFFF_FFFF, 32'd65535, 32'd0, 32'hFFFF_FFFF};
        cfg[2] = '{32'd1000, 32'd0, 32'hFFFF_FFFF, 32'd0};
        cfg[3] = '{32'd0, 32'd256, 32'd100, 32'd100000};
        cfg[4] = '{32'd12345678, 32'd40000, 32'd0, 32'd0};
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        repeat (200) @(posedge aclk);
        configure(cfg[0][0], cfg[0][1], cfg[0][2], cfg[0][3]);

        // extremes of height and variance, gate pass, reject, far miss
        send(OP_FUSE, 7'd0, 7'd0, 32'h7FFF_FFFF, 32'd0);
        send(OP_FUSE, 7'd0, 7'd0, 32'h7FFF_FFFF - 1000, 32'd0);
        send(OP_FUSE, 7'd0, 7'd0, 32'h0, 32'd5);
        send(OP_FUSE, 7'd127, 7'd127, 32'h8000_0000, 32'hFFFF_FFFF);
        send(OP_FUSE, 7'd127, 7'd127, 32'h8000_0000 + 5000, 32'd1000);
        send(OP_FUSE, 7'd127, 7'd0, 32'h1234_5678, 32'h5555_5555);
        send(OP_FUSE, 7'd0, 7'd127, 32'hFFFF_FFFF, 32'hAAAA_AAAA);
        send(OP_FUSE, 7'd127, 7'd0, 32'h1234_5678 + 32'h0FFF_FFFF, 32'd1);
        send(OP_SWEEP, 7'd127, 7'd127, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        drain();

        // zero variance floor: a zero variance sum keeps the cell
        configure(32'd0, 32'd65535, 32'd0, 32'hFFFF_FFFF);
        send(OP_FUSE, 7'd5, 7'd5, 32'h100, 32'd0);
        send(OP_FUSE, 7'd5, 7'd5, 32'h100, 32'd0);
        send(OP_FUSE, 7'd5, 7'd5, 32'h101, 32'd0);
        send(OP_FUSE, 7'd5, 7'd5, 32'h100, 32'd7);
        send(OP_SWEEP, 7'd0, 7'd0, 32'd0, 32'd0);
        drain();

        for (int p = 0; p < 5; p++) begin
            configure(cfg[p][0], cfg[p][1], cfg[p][2], cfg[p][3]);
            no_idle = (p == 1);
            if (p == 2) long_hold = 1'b1;
            for (int n = 0; n < 108; n++) begin
                if (p == 3 && n == 50) begin
                    // hold the sender until the block has answered everything
                    s_tvalid <= 1'b0;
                    while (board.outstanding() > 0) @(posedge aclk);
                end
                if ($urandom_range(0, 199) == 0)
                    send(OP_SWEEP, 7'($urandom), 7'($urandom), $urandom, $urandom);
                else
                    random_point();
            end
            send(OP_SWEEP, 7'($urandom), 7'($urandom), $urandom, $urandom);
            drain();
        end

        if (board.mismatches == 0 && board.outstanding() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end
endmodule

[sim.f]
+incdir+hw/rtl
hw/rtl/ecf_pkg.sv
hw/rtl/ecf_div.sv
hw/rtl/ecf_datapath.sv
hw/rtl/ecf_ctrl.sv
hw/rtl/elevation_cell_kalman_fusion_unit.sv
sim/testbench.sv
